// File: src/sfb_pkg.sv
// Shared constants, widths and the exponent factor table for the softmax core.
package sfb_pkg;

  localparam int ROW_LEN_DEF = 16;
  localparam int VAL_W       = 16;
  localparam int OUT_W       = 17;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;
  localparam int MUL_W       = 33;
  localparam int EXP_BITS    = 16;
  localparam int BIT_W       = $clog2(EXP_BITS);
  localparam int E_W         = 33;
  localparam int QUO_W       = 17;
  localparam int DLO_W       = 24;

  localparam logic [31:0] EXP_STEP_Q32 = 32'd4278222805;

  // Factor for bit b of the exponent argument is exp(-2^b/256) in Q0.32,
  // built by the same rounded squaring that the datapath relies on.
  function automatic logic [EXP_BITS-1:0][31:0] exp_factor_table();
    logic [63:0] c;
    logic [EXP_BITS-1:0][31:0] t;
    int b;
    c = {32'b0, EXP_STEP_Q32};
    for (b = 0; b < EXP_BITS; b++) begin
      t[b] = c[31:0];
      c = (c * c + 64'h0000_0000_8000_0000) >> 32;
    end
    return t;
  endfunction

  localparam logic [EXP_BITS-1:0][31:0] EXP_FACTORS = exp_factor_table();

endpackage

// File: src/sfb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sfb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/sfb_mul.sv
// Shared signed multiplier with a registered product.
module sfb_mul import sfb_pkg::*; (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [MUL_W-1:0]     a,
  input  logic signed [MUL_W-1:0]     b,
  output logic signed [2*MUL_W-1:0]   prod_r
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * b;
    end
  end

endmodule

// File: src/sfb_div.sv
// Restoring divider, one quotient bit per cycle.
module sfb_div #(
  parameter int NUM_W = 49,
  parameter int DEN_W = 37,
  parameter int QUO_W = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo,
  output logic             done
);

  localparam int DSH_W = DEN_W + QUO_W - 1;
  localparam int CMP_W = (NUM_W > DSH_W) ? NUM_W : DSH_W;
  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [NUM_W-1:0] rem_r;
  logic [DSH_W-1:0] dsh_r;
  logic [QUO_W-1:0] quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [CMP_W-1:0] rem_ext;
  logic [CMP_W-1:0] dsh_ext;
  logic [CMP_W-1:0] diff;
  logic             ge;

  assign rem_ext = CMP_W'(rem_r);
  assign dsh_ext = CMP_W'(dsh_r);
  assign ge      = rem_ext >= dsh_ext;
  assign diff    = rem_ext - dsh_ext;
  assign quo     = quo_r;
  assign done    = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(QUO_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      dsh_r <= {den, {(QUO_W-1){1'b0}}};
      quo_r <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= diff[NUM_W-1:0];
      end
      quo_r <= {quo_r[QUO_W-2:0], ge};
      dsh_r <= dsh_r >> 1;
    end
  end

endmodule

// File: src/softmax_forward_backward_core.sv
// Row softmax with Jacobian backward pass, sequenced over one shared multiplier.
//
//   channel | direction | tdata                | tuser         | tlast
//   in_     | input     | [15:0] in_value Q8.8 | [0] func      | last element
//   out_    | output    | [16:0] out_value     | [0] row_error | last result
//
// Elements of a row load at one per cycle. The last element starts the row pass:
// forward finds the maximum, then computes each exponent (one step per argument
// bit plus a rounding step for each set bit above the lowest one) and divides
// each one by the sum in the 17-step divider; backward forms the weighted sum,
// then each result.
// The input is not ready during a row pass; a stalled output holds the pass.
// Reset is synchronous; kept probabilities read as zero until first written.
module softmax_forward_backward_core import sfb_pkg::*; #(
  parameter int ROW_LEN = ROW_LEN_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] in_value
  input  logic [0:0]             in_tuser,   // [0] func
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [16:0] out_value, rest zero
  output logic [0:0]             out_tuser,  // [0] row_error
  output logic                   out_tlast
);

  localparam int IW     = $clog2(ROW_LEN);
  localparam int CW     = $clog2(ROW_LEN + 1);
  localparam int SUM_W  = E_W + IW;
  localparam int NUM_W  = E_W + 16;
  localparam int S_W    = 33 + IW;
  localparam int D_W    = S_W + 1;
  localparam int DHI_W  = D_W - DLO_W;
  localparam int ACC_W  = D_W + 17;
  localparam int RES_W  = ACC_W - 32;

  localparam logic [4:0] S_LOAD     = 5'd0;
  localparam logic [4:0] F_MAX_RD   = 5'd1;
  localparam logic [4:0] F_MAX      = 5'd2;
  localparam logic [4:0] F_EXP_RD   = 5'd3;
  localparam logic [4:0] F_EXP_INIT = 5'd4;
  localparam logic [4:0] F_EXP_BIT  = 5'd5;
  localparam logic [4:0] F_EXP_RND  = 5'd6;
  localparam logic [4:0] F_EXP_WR   = 5'd7;
  localparam logic [4:0] F_DIV_RD   = 5'd8;
  localparam logic [4:0] F_DIV_GO   = 5'd9;
  localparam logic [4:0] F_DIV_WAIT = 5'd10;
  localparam logic [4:0] F_EMIT     = 5'd11;
  localparam logic [4:0] B_SUM_RD   = 5'd12;
  localparam logic [4:0] B_SUM_MUL  = 5'd13;
  localparam logic [4:0] B_SUM_ACC  = 5'd14;
  localparam logic [4:0] B_RD       = 5'd15;
  localparam logic [4:0] B_D        = 5'd16;
  localparam logic [4:0] B_MUL_LO   = 5'd17;
  localparam logic [4:0] B_ACC_LO   = 5'd18;
  localparam logic [4:0] B_ACC_HI   = 5'd19;
  localparam logic [4:0] B_EMIT     = 5'd20;

  localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(EXP_BITS - 1);

  logic [4:0]              state_r, state_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [CW-1:0]           n_r, n_nxt;
  logic                    func_r, func_nxt;
  logic                    err_r, err_nxt;
  logic [IW-1:0]           idx_r, idx_nxt;
  logic signed [VAL_W-1:0] mx_r, mx_nxt;
  logic [15:0]             a_r, a_nxt;
  logic [BIT_W-1:0]        bit_r, bit_nxt;
  logic [31:0]             r_r, r_nxt;
  logic                    r_one_r, r_one_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic [S_W-1:0]          s_r, s_nxt;
  logic [D_W-1:0]          d_r, d_nxt;
  logic [15:0]             y_r, y_nxt;
  logic [ACC_W-1:0]        acc_r, acc_nxt;
  logic [CW-1:0]           stored_len_r, stored_len_nxt;
  logic [ROW_LEN-1:0]      pvld_r, pvld_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]        out_data_r, out_data_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    out_err_r, out_err_nxt;

  logic                    in_fire, full, idx_last, out_free, out_load;
  logic [CW-1:0]           n_in;
  logic                    rb_we, ps_we, er_we;
  logic [VAL_W-1:0]        rb_q, ps_q;
  logic [E_W-1:0]          er_q, e_val;
  logic signed [VAL_W-1:0] x_s;
  logic [16:0]             diff;
  logic [63:0]             rnd;
  logic [15:0]             y_val;
  logic                    mul_en;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [2*MUL_W-1:0] prod_r;
  logic                    div_start, div_done;
  logic [QUO_W-1:0]        div_quo;
  logic [NUM_W-1:0]        div_num;
  logic [15:0]             quo_sat;
  logic [ACC_W-1:0]        acc_rnd;
  logic [RES_W-1:0]        qv;
  logic [15:0]             res_sat;
  logic [D_W-1:0]          g_ext;

  assign in_tready = (state_r == S_LOAD);
  assign in_fire   = in_tvalid & in_tready;
  assign full      = count_r >= CW'(ROW_LEN);
  assign n_in      = full ? count_r : count_r + CW'(1);
  assign idx_last  = (CW'(idx_r) + CW'(1)) == n_r;
  assign out_free  = !out_valid_r || out_tready;

  assign x_s     = rb_q;
  assign diff    = {mx_r[VAL_W-1], mx_r} - {x_s[VAL_W-1], x_s};
  assign rnd     = prod_r[63:0] + 64'h0000_0000_8000_0000;
  assign e_val   = r_one_r ? {1'b1, 32'b0} : {1'b0, r_r};
  assign y_val   = pvld_r[idx_r] ? ps_q : 16'h0000;
  assign div_num = {er_q, 16'b0} + NUM_W'(sum_r >> 1);
  assign quo_sat = div_quo[QUO_W-1] ? 16'hFFFF : div_quo[15:0];
  assign g_ext   = {{(D_W-32){x_s[VAL_W-1]}}, x_s, 16'b0};

  // Round to nearest toward plus infinity, then clamp to the signed Q8.8 range.
  assign acc_rnd = acc_r + (ACC_W'(1) << 31);
  assign qv      = acc_rnd[ACC_W-1:32];
  always_comb begin
    if (!qv[RES_W-1] && (|qv[RES_W-2:15])) begin
      res_sat = 16'h7FFF;
    end else if (qv[RES_W-1] && !(&qv[RES_W-2:15])) begin
      res_sat = 16'h8000;
    end else begin
      res_sat = qv[15:0];
    end
  end

  sfb_ram #(.WIDTH(VAL_W), .DEPTH(ROW_LEN)) u_row_buf (
    .clk(clk), .we(rb_we), .waddr(count_r[IW-1:0]), .wdata(in_tdata[VAL_W-1:0]),
    .raddr(idx_r), .rdata(rb_q)
  );

  sfb_ram #(.WIDTH(VAL_W), .DEPTH(ROW_LEN)) u_prob (
    .clk(clk), .we(ps_we), .waddr(idx_r), .wdata(quo_sat),
    .raddr(idx_r), .rdata(ps_q)
  );

  sfb_ram #(.WIDTH(E_W), .DEPTH(ROW_LEN)) u_exp (
    .clk(clk), .we(er_we), .waddr(idx_r), .wdata(e_val),
    .raddr(idx_r), .rdata(er_q)
  );

  sfb_mul u_mul (
    .clk(clk), .en(mul_en), .a(mul_a), .b(mul_b), .prod_r(prod_r)
  );

  sfb_div #(.NUM_W(NUM_W), .DEN_W(SUM_W), .QUO_W(QUO_W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(sum_r),
    .quo(div_quo), .done(div_done)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_r)
      F_EXP_BIT: begin
        mul_en = a_r[bit_r] && !r_one_r;
        mul_a  = {1'b0, r_r};
        mul_b  = {1'b0, EXP_FACTORS[bit_r]};
      end
      B_SUM_MUL: begin
        mul_en = 1'b1;
        mul_a  = {{(MUL_W-VAL_W){rb_q[VAL_W-1]}}, rb_q};
        mul_b  = {{(MUL_W-16){1'b0}}, y_val};
      end
      B_MUL_LO: begin
        mul_en = 1'b1;
        mul_a  = {{(MUL_W-16){1'b0}}, y_r};
        mul_b  = {{(MUL_W-DLO_W){1'b0}}, d_r[DLO_W-1:0]};
      end
      B_ACC_LO: begin
        mul_en = 1'b1;
        mul_a  = {{(MUL_W-16){1'b0}}, y_r};
        mul_b  = {{(MUL_W-DHI_W){d_r[D_W-1]}}, d_r[D_W-1:DLO_W]};
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ovf_nxt        = ovf_r;
    n_nxt          = n_r;
    func_nxt       = func_r;
    err_nxt        = err_r;
    idx_nxt        = idx_r;
    mx_nxt         = mx_r;
    a_nxt          = a_r;
    bit_nxt        = bit_r;
    r_nxt          = r_r;
    r_one_nxt      = r_one_r;
    sum_nxt        = sum_r;
    s_nxt          = s_r;
    d_nxt          = d_r;
    y_nxt          = y_r;
    acc_nxt        = acc_r;
    stored_len_nxt = stored_len_r;
    pvld_nxt       = pvld_r;
    rb_we          = 1'b0;
    ps_we          = 1'b0;
    er_we          = 1'b0;
    div_start      = 1'b0;
    out_load       = 1'b0;
    out_data_nxt   = out_data_r;
    out_last_nxt   = out_last_r;
    out_err_nxt    = out_err_r;

    unique case (state_r)
      S_LOAD: begin
        if (in_fire) begin
          if (!full) begin
            rb_we     = 1'b1;
            count_nxt = count_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            n_nxt     = n_in;
            func_nxt  = in_tuser[0];
            err_nxt   = ovf_r | full | (in_tuser[0] & (n_in != stored_len_r));
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            idx_nxt   = '0;
            sum_nxt   = '0;
            s_nxt     = '0;
            state_nxt = in_tuser[0] ? B_SUM_RD : F_MAX_RD;
          end
        end
      end
      F_MAX_RD: begin
        state_nxt = F_MAX;
      end
      F_MAX: begin
        if ((idx_r == '0) || (x_s > mx_r)) begin
          mx_nxt = x_s;
        end
        if (idx_last) begin
          idx_nxt   = '0;
          state_nxt = F_EXP_RD;
        end else begin
          idx_nxt   = idx_r + IW'(1);
          state_nxt = F_MAX_RD;
        end
      end
      F_EXP_RD: begin
        state_nxt = F_EXP_INIT;
      end
      F_EXP_INIT: begin
        a_nxt     = diff[15:0];
        r_one_nxt = 1'b1;
        bit_nxt   = '0;
        state_nxt = F_EXP_BIT;
      end
      F_EXP_BIT: begin
        if (a_r[bit_r] && !r_one_r) begin
          state_nxt = F_EXP_RND;
        end else begin
          // Multiplying exactly one by the factor gives the factor itself.
          if (a_r[bit_r]) begin
            r_nxt     = EXP_FACTORS[bit_r];
            r_one_nxt = 1'b0;
          end
          if (bit_r == LAST_BIT) begin
            state_nxt = F_EXP_WR;
          end else begin
            bit_nxt = bit_r + BIT_W'(1);
          end
        end
      end
      F_EXP_RND: begin
        r_nxt = rnd[63:32];
        if (bit_r == LAST_BIT) begin
          state_nxt = F_EXP_WR;
        end else begin
          bit_nxt   = bit_r + BIT_W'(1);
          state_nxt = F_EXP_BIT;
        end
      end
      F_EXP_WR: begin
        er_we   = 1'b1;
        sum_nxt = sum_r + SUM_W'(e_val);
        if (idx_last) begin
          idx_nxt   = '0;
          state_nxt = F_DIV_RD;
        end else begin
          idx_nxt   = idx_r + IW'(1);
          state_nxt = F_EXP_RD;
        end
      end
      F_DIV_RD: begin
        state_nxt = F_DIV_GO;
      end
      F_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = F_DIV_WAIT;
      end
      F_DIV_WAIT: begin
        if (div_done) begin
          state_nxt = F_EMIT;
        end
      end
      F_EMIT: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_data_nxt    = {1'b0, quo_sat};
          out_last_nxt    = idx_last;
          out_err_nxt     = err_r;
          ps_we           = 1'b1;
          pvld_nxt[idx_r] = 1'b1;
          if (idx_last) begin
            stored_len_nxt = n_r;
            state_nxt      = S_LOAD;
          end else begin
            idx_nxt   = idx_r + IW'(1);
            state_nxt = F_DIV_RD;
          end
        end
      end
      B_SUM_RD: begin
        state_nxt = B_SUM_MUL;
      end
      B_SUM_MUL: begin
        state_nxt = B_SUM_ACC;
      end
      B_SUM_ACC: begin
        s_nxt = s_r + prod_r[S_W-1:0];
        if (idx_last) begin
          idx_nxt   = '0;
          state_nxt = B_RD;
        end else begin
          idx_nxt   = idx_r + IW'(1);
          state_nxt = B_SUM_RD;
        end
      end
      B_RD: begin
        state_nxt = B_D;
      end
      B_D: begin
        d_nxt     = g_ext - {s_r[S_W-1], s_r};
        y_nxt     = y_val;
        state_nxt = B_MUL_LO;
      end
      B_MUL_LO: begin
        state_nxt = B_ACC_LO;
      end
      B_ACC_LO: begin
        acc_nxt   = prod_r[ACC_W-1:0];
        state_nxt = B_ACC_HI;
      end
      B_ACC_HI: begin
        acc_nxt   = acc_r + {prod_r[ACC_W-DLO_W-1:0], {DLO_W{1'b0}}};
        state_nxt = B_EMIT;
      end
      B_EMIT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_data_nxt = {res_sat[15], res_sat};
          out_last_nxt = idx_last;
          out_err_nxt  = err_r;
          if (idx_last) begin
            state_nxt = S_LOAD;
          end else begin
            idx_nxt   = idx_r + IW'(1);
            state_nxt = B_RD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase

    out_valid_nxt = out_load | (out_valid_r & !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      count_r      <= '0;
      ovf_r        <= 1'b0;
      stored_len_r <= '0;
      pvld_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      ovf_r        <= ovf_nxt;
      stored_len_r <= stored_len_nxt;
      pvld_r       <= pvld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    func_r     <= func_nxt;
    err_r      <= err_nxt;
    idx_r      <= idx_nxt;
    mx_r       <= mx_nxt;
    a_r        <= a_nxt;
    bit_r      <= bit_nxt;
    r_r        <= r_nxt;
    r_one_r    <= r_one_nxt;
    sum_r      <= sum_nxt;
    s_r        <= s_nxt;
    d_r        <= d_nxt;
    y_r        <= y_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-OUT_W){1'b0}}, out_data_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ROW_LEN))
    else $error("element count beyond row length");

  a_idx_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_LOAD) |-> (CW'(idx_r) < n_r))
    else $error("row index beyond row length during a pass");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == F_DIV_WAIT))
    else $error("divider finished outside its wait state");

  a_stored_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == F_EMIT && out_load && idx_last) |=> (stored_len_r == $past(n_r)))
    else $error("forward row end did not record its length");

endmodule

// File: tb/sv/softmax_forward_backward_checker.sv
// Checker for the softmax core: predicts each row's results and compares them.
module softmax_forward_backward_checker import sfb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [0:0]             in_tuser,
  input  logic                   in_tlast,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic [0:0]             out_tuser,
  input  logic                   out_tlast,
  output int                     error_count,
  output int                     rows_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic             last;
    logic             err;
  } result_t;

  result_t             expected_results[$];
  logic [VAL_W-1:0]    row_vals[ROW_LEN_DEF];
  logic [VAL_W-1:0]    kept_probs[ROW_LEN_DEF];
  int                  row_count;
  int                  kept_len;
  logic                row_overflow;

  initial error_count = 0;
  assign rows_pending = expected_results.size();

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  // exp(-a/256) in Q0.32 by rounded square-and-multiply.
  function automatic logic [63:0] exp_q32(input logic [15:0] a);
    logic [63:0] r;
    logic [63:0] c;
    r = 64'h1_0000_0000;
    c = {32'b0, EXP_STEP_Q32};
    for (int b = 0; b < 16; b++) begin
      if (a[b]) r = (r * c + 64'h8000_0000) >> 32;
      c = (c * c + 64'h8000_0000) >> 32;
    end
    return r;
  endfunction

  task automatic finish_row(input logic backward);
    logic [63:0] e[ROW_LEN_DEF];
    logic [63:0] total;
    logic [63:0] p;
    longint      mx, s, d, q;
    logic        err;
    result_t     r;
    total = 0;
    err = row_overflow;
    if (!backward) begin
      mx = longint'($signed(row_vals[0]));
      for (int j = 1; j < row_count; j++)
        if (longint'($signed(row_vals[j])) > mx) mx = longint'($signed(row_vals[j]));
      for (int j = 0; j < row_count; j++) begin
        e[j] = exp_q32(16'(mx - longint'($signed(row_vals[j]))));
        total += e[j];
      end
      for (int j = 0; j < row_count; j++) begin
        p = (e[j] * 65536 + total / 2) / total;
        if (p > 65535) p = 65535;
        kept_probs[j] = p[15:0];
        r.value = {1'b0, p[15:0]};
        r.last = (j == row_count - 1);
        r.err = err;
        expected_results.push_back(r);
      end
      kept_len = row_count;
    end else begin
      s = 0;
      if (row_count != kept_len) err = 1'b1;
      for (int j = 0; j < row_count; j++)
        s += longint'($signed(row_vals[j])) * longint'(kept_probs[j]);
      for (int j = 0; j < row_count; j++) begin
        d = longint'($signed(row_vals[j])) * 65536 - s;
        q = (longint'(kept_probs[j]) * d + 64'sh8000_0000) >>> 32;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        r.value = q[OUT_W-1:0];
        r.last = (j == row_count - 1);
        r.err = err;
        expected_results.push_back(r);
      end
    end
    row_count = 0;
    row_overflow = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      row_count = 0;
      kept_len = 0;
      row_overflow = 1'b0;
      for (int j = 0; j < ROW_LEN_DEF; j++) kept_probs[j] = '0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (row_count < ROW_LEN_DEF) begin
          row_vals[row_count] = in_tdata[VAL_W-1:0];
          row_count++;
        end else begin
          row_overflow = 1'b1;
        end
        if (in_tlast) finish_row(in_tuser[0]);
      end
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report($sformatf("unexpected result value %h", out_tdata));
        end else begin
          result_t w;
          w = expected_results.pop_front();
          if (out_tdata[OUT_W-1:0] !== w.value)
            report($sformatf("value %h, want %h", out_tdata[OUT_W-1:0], w.value));
          if (out_tdata[OUT_TDATA_W-1:OUT_W] !== '0)
            report($sformatf("padding bits %h not zero", out_tdata));
          if (out_tlast !== w.last)
            report($sformatf("last %b, want %b", out_tlast, w.last));
          if (out_tuser[0] !== w.err)
            report($sformatf("row error %b, want %b", out_tuser[0], w.err));
        end
      end
    end
  end
endmodule

// File: tb/sv/softmax_forward_backward_core_tb.sv
// Testbench top for the softmax core: stimulus, back pressure and the verdict.
module softmax_forward_backward_core_tb import sfb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;
  localparam logic FWD = 1'b0;
  localparam logic BWD = 1'b1;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [0:0]             in_tuser;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [0:0]             out_tuser;
  logic                   out_tlast;
  int                     error_count;
  int                     rows_pending;
  logic                   steady;
  int                     quiet_cycles;
  int                     sent;

  softmax_forward_backward_core dut (.*);
  softmax_forward_backward_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) out_tready <= steady || ($urandom_range(99) >= 38);

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_elem(input logic mode, input logic [15:0] v, input logic last);
    while (!steady && $urandom_range(99) < 38) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= v;
    in_tuser <= mode;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(2047)) - 1024);
      2: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      default: return 16'($signed($urandom_range(255)) - 128);
    endcase
  endfunction

  // Sends one row whose mode comes from the last element; earlier ones get noise.
  task automatic send_row(input logic mode, input int len);
    for (int i = 0; i < len; i++)
      send_elem((i == len - 1) ? mode : logic'($urandom_range(1)), pick_value(),
                i == len - 1);
  endtask

  initial begin
    int len;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    steady = 1'b0;
    quiet_cycles = 0;
    sent = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Backward before any forward row, against an all-zero probability store.
    send_elem(BWD, 16'h0100, 1'b0);
    send_elem(BWD, 16'h8000, 1'b1);
    // Single-element forward row, then extremes giving the widest exponent argument.
    send_elem(FWD, 16'h1234, 1'b1);
    send_elem(FWD, 16'h7FFF, 1'b0);
    send_elem(FWD, 16'h8000, 1'b0);
    send_elem(FWD, 16'h0000, 1'b0);
    send_elem(FWD, 16'h7FFF, 1'b1);
    send_elem(BWD, 16'h7FFF, 1'b0);
    send_elem(BWD, 16'h8000, 1'b0);
    send_elem(BWD, 16'hFFFF, 1'b0);
    send_elem(BWD, 16'h0001, 1'b1);
    // Backward row with the wrong length.
    send_elem(BWD, 16'h0200, 1'b0);
    send_elem(BWD, 16'hFE00, 1'b1);
    // Over-long forward row with mixed mode bits.
    for (int i = 0; i < 18; i++)
      send_elem((i == 17) ? FWD : logic'(i % 2), 16'(i * 97), i == 17);

    // Hold off until every pending result has drained.
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (rows_pending != 0) @(posedge clk);

    while (sent < 325) begin
      steady = (sent >= 200 && sent < 250);
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 17) : $urandom_range(6, 1);
      if ($urandom_range(19) == 0) len = 16;
      send_row(FWD, len);
      if ($urandom_range(9) < 8)
        send_row(BWD, ($urandom_range(9) == 0) ? $urandom_range(17, 1) : len);
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (rows_pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_count == 0 && rows_pending == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
